@@ src/qcq_pkg.sv @@
// ---------------------------------------------------------------------------
// qcq_pkg
// Shared types, codes and saturating Q16.16 helpers for the quadrant
// classifier.
// ---------------------------------------------------------------------------
package qcq_pkg;

	// signed Q16.16 word
	typedef logic signed [31:0] q_t;
	// product after dropping 16 fraction bits (floor)
	typedef logic signed [47:0] prod_t;
	// compare width for corners and child bounds
	typedef logic signed [34:0] wide_t;

	localparam q_t Q_MAX = 32'sh7FFF_FFFF;
	localparam q_t Q_MIN = 32'sh8000_0000;

	// request function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_BOX  = 1'b1;

	// no child holds the footprint
	localparam logic [2:0] QUAD_NONE = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Z = 2'd1;
	localparam logic [1:0] REG_HALF_X   = 2'd2;
	localparam logic [1:0] REG_HALF_Z   = 2'd3;

	// node geometry registers
	typedef struct packed {
		q_t          center_x;
		q_t          center_z;
		logic [30:0] half_x;
		logic [30:0] half_z;
	} node_t;

	// one queued request: truncated products plus translations
	typedef struct packed {
		prod_t [2:0] cx_p;
		prod_t [2:0] cz_p;
		prod_t [2:0] ex_p;
		prod_t [2:0] ez_p;
		q_t          tx;
		q_t          tz;
	} work_t;

	// clamp a truncated product to 32 bits
	function automatic q_t sat_prod(input prod_t p);
		if (p[47:31] == {17{p[47]}}) begin
			return p[31:0];
		end
		return p[47] ? Q_MIN : Q_MAX;
	endfunction

	// saturating add
	function automatic q_t sat_add(input q_t a, input q_t b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? Q_MIN : Q_MAX;
		end
		return s[31:0];
	endfunction

	// saturating absolute value
	function automatic q_t sat_abs(input q_t a);
		if (a == Q_MIN) begin
			return Q_MAX;
		end
		return a[31] ? -a : a;
	endfunction

endpackage

@@ src/qcq_item_if.sv @@
// ---------------------------------------------------------------------------
// qcq_item_if
// Request channel: function code and eight Q16.16 words.
// ---------------------------------------------------------------------------
interface qcq_item_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic signed [31:0] value_0;
	logic signed [31:0] value_1;
	logic signed [31:0] value_2;
	logic signed [31:0] value_3;
	logic signed [31:0] value_4;
	logic signed [31:0] value_5;
	logic signed [31:0] value_6;
	logic signed [31:0] value_7;

	modport source (
		output valid, func, value_0, value_1, value_2, value_3,
		       value_4, value_5, value_6, value_7,
		input  ready
	);
	modport sink (
		input  valid, func, value_0, value_1, value_2, value_3,
		       value_4, value_5, value_6, value_7,
		output ready
	);
endinterface

@@ src/qcq_result_if.sv @@
// ---------------------------------------------------------------------------
// qcq_result_if
// Result channel: quadrant code.
// ---------------------------------------------------------------------------
interface qcq_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] quadrant;

	modport source (output valid, quadrant, input ready);
	modport sink (input valid, quadrant, output ready);
endinterface

@@ src/qcq_front.sv @@
// ---------------------------------------------------------------------------
// qcq_front
// Accepts requests, latches matrix entries on loads and forms the twelve
// registered products for each box request.
// ---------------------------------------------------------------------------
module qcq_front (
	input  logic            clk,
	input  logic            arst_n,
	qcq_item_if.sink        items,
	output logic            push_valid,
	input  logic            push_ready,
	output qcq_pkg::work_t  push_data
);

	qcq_pkg::q_t    m_q [8];
	qcq_pkg::q_t    v [8];
	logic           s1_valid_q;
	qcq_pkg::work_t s1_data_s1;
	logic           accept;

	// signed product with the 16 fraction bits floored away
	function automatic qcq_pkg::prod_t mul_q(input qcq_pkg::q_t a, input qcq_pkg::q_t b);
		logic signed [63:0] p;
		p = a * b;
		return p[63:16];
	endfunction

	assign v[0] = items.value_0;
	assign v[1] = items.value_1;
	assign v[2] = items.value_2;
	assign v[3] = items.value_3;
	assign v[4] = items.value_4;
	assign v[5] = items.value_5;
	assign v[6] = items.value_6;
	assign v[7] = items.value_7;

	// slot frees when empty or when the queue takes it
	assign items.ready = !s1_valid_q || push_ready;
	assign accept      = items.valid && items.ready;

	// matrix entries, row-vector x and z columns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) m_q[k] <= '0;
		end else if (accept && items.func == qcq_pkg::FUNC_LOAD) begin
			for (int k = 0; k < 8; k++) m_q[k] <= v[k];
		end
	end

	// product stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (items.ready) begin
			s1_valid_q <= accept && items.func == qcq_pkg::FUNC_BOX;
		end
	end

	// product stage payload
	always_ff @(posedge clk) begin
		if (accept && items.func == qcq_pkg::FUNC_BOX) begin
			s1_data_s1.cx_p[0] <= mul_q(v[3], m_q[0]);
			s1_data_s1.cx_p[1] <= mul_q(v[4], m_q[1]);
			s1_data_s1.cx_p[2] <= mul_q(v[5], m_q[2]);
			s1_data_s1.cz_p[0] <= mul_q(v[3], m_q[4]);
			s1_data_s1.cz_p[1] <= mul_q(v[4], m_q[5]);
			s1_data_s1.cz_p[2] <= mul_q(v[5], m_q[6]);
			s1_data_s1.ex_p[0] <= mul_q(v[0], m_q[0]);
			s1_data_s1.ex_p[1] <= mul_q(v[1], m_q[1]);
			s1_data_s1.ex_p[2] <= mul_q(v[2], m_q[2]);
			s1_data_s1.ez_p[0] <= mul_q(v[0], m_q[4]);
			s1_data_s1.ez_p[1] <= mul_q(v[1], m_q[5]);
			s1_data_s1.ez_p[2] <= mul_q(v[2], m_q[6]);
			s1_data_s1.tx      <= m_q[3];
			s1_data_s1.tz      <= m_q[7];
		end
	end

	assign push_valid = s1_valid_q;
	assign push_data  = s1_data_s1;

endmodule

@@ src/qcq_fifo.sv @@
// ---------------------------------------------------------------------------
// qcq_fifo
// Two-entry queue of product sets between the front and the back.
// ---------------------------------------------------------------------------
module qcq_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  qcq_pkg::work_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output qcq_pkg::work_t  pop_data
);

	qcq_pkg::work_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/qcq_back.sv @@
// ---------------------------------------------------------------------------
// qcq_back
// Saturating sums of the queued products, footprint corners and the
// child containment test, ending in the result register.
// ---------------------------------------------------------------------------
module qcq_back (
	input  logic            clk,
	input  logic            arst_n,
	input  qcq_pkg::node_t  node,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  qcq_pkg::work_t  pop_data,
	qcq_result_if.source    results
);

	logic v1_q, v2_q, v3_q, v4_q, out_valid_q;
	logic en1, en2, en3, en4, en_o;

	qcq_pkg::q_t   cx_s1, cz_s1, ex_s1, ez_s1, cx2_s1, cz2_s1, ex2_s1, ez2_s1, tx_s1, tz_s1;
	qcq_pkg::q_t   cx_s2, cz_s2, ex_s2, ez_s2, tx_s2, tz_s2;
	qcq_pkg::q_t   cx_s3, cz_s3, ex_s3, ez_s3;
	qcq_pkg::wide_t lox_s4, hix_s4, loz_s4, hiz_s4;
	logic [2:0]    quadrant_q;

	qcq_pkg::wide_t ncx, ncz, dx, dz;
	logic xlo, xhi, zlo, zhi;
	logic [2:0] quad_d;

	// stall chain from the result register backward
	assign en_o      = !out_valid_q || results.ready;
	assign en4       = !v4_q || en_o;
	assign en3       = !v3_q || en4;
	assign en2       = !v2_q || en3;
	assign en1       = !v1_q || en2;
	assign pop_ready = en1;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q        <= 1'b0;
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			v4_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1)  v1_q        <= pop_valid;
			if (en2)  v2_q        <= v1_q;
			if (en3)  v3_q        <= v2_q;
			if (en4)  v4_q        <= v3_q;
			if (en_o) out_valid_q <= v4_q;
		end
	end

	// clamp products, first sums
	always_ff @(posedge clk) begin
		if (en1) begin
			cx_s1  <= qcq_pkg::sat_add(qcq_pkg::sat_prod(pop_data.cx_p[0]),
			                          qcq_pkg::sat_prod(pop_data.cx_p[1]));
			cz_s1  <= qcq_pkg::sat_add(qcq_pkg::sat_prod(pop_data.cz_p[0]),
			                          qcq_pkg::sat_prod(pop_data.cz_p[1]));
			ex_s1  <= qcq_pkg::sat_add(qcq_pkg::sat_abs(qcq_pkg::sat_prod(pop_data.ex_p[0])),
			                          qcq_pkg::sat_abs(qcq_pkg::sat_prod(pop_data.ex_p[1])));
			ez_s1  <= qcq_pkg::sat_add(qcq_pkg::sat_abs(qcq_pkg::sat_prod(pop_data.ez_p[0])),
			                          qcq_pkg::sat_abs(qcq_pkg::sat_prod(pop_data.ez_p[1])));
			cx2_s1 <= qcq_pkg::sat_prod(pop_data.cx_p[2]);
			cz2_s1 <= qcq_pkg::sat_prod(pop_data.cz_p[2]);
			ex2_s1 <= qcq_pkg::sat_abs(qcq_pkg::sat_prod(pop_data.ex_p[2]));
			ez2_s1 <= qcq_pkg::sat_abs(qcq_pkg::sat_prod(pop_data.ez_p[2]));
			tx_s1  <= pop_data.tx;
			tz_s1  <= pop_data.tz;
		end
	end

	// third term
	always_ff @(posedge clk) begin
		if (en2) begin
			cx_s2 <= qcq_pkg::sat_add(cx_s1, cx2_s1);
			cz_s2 <= qcq_pkg::sat_add(cz_s1, cz2_s1);
			ex_s2 <= qcq_pkg::sat_add(ex_s1, ex2_s1);
			ez_s2 <= qcq_pkg::sat_add(ez_s1, ez2_s1);
			tx_s2 <= tx_s1;
			tz_s2 <= tz_s1;
		end
	end

	// translation
	always_ff @(posedge clk) begin
		if (en3) begin
			cx_s3 <= qcq_pkg::sat_add(cx_s2, tx_s2);
			cz_s3 <= qcq_pkg::sat_add(cz_s2, tz_s2);
			ex_s3 <= ex_s2;
			ez_s3 <= ez_s2;
		end
	end

	// footprint corners at full width
	always_ff @(posedge clk) begin
		if (en4) begin
			lox_s4 <= 35'(cx_s3) - 35'(ex_s3);
			hix_s4 <= 35'(cx_s3) + 35'(ex_s3);
			loz_s4 <= 35'(cz_s3) - 35'(ez_s3);
			hiz_s4 <= 35'(cz_s3) + 35'(ez_s3);
		end
	end

	// child bounds: node center, and center -/+ twice the child half size
	assign ncx = 35'(node.center_x);
	assign ncz = 35'(node.center_z);
	assign dx  = $signed({4'b0, node.half_x[30:1], 1'b0});
	assign dz  = $signed({4'b0, node.half_z[30:1], 1'b0});

	assign xlo = (ncx - dx <= lox_s4) && (hix_s4 <= ncx);
	assign xhi = (ncx <= lox_s4) && (hix_s4 <= ncx + dx);
	assign zlo = (ncz - dz <= loz_s4) && (hiz_s4 <= ncz);
	assign zhi = (ncz <= loz_s4) && (hiz_s4 <= ncz + dz);

	// first fitting quadrant in order
	always_comb begin
		if (xlo && zlo)      quad_d = 3'd0;
		else if (xlo && zhi) quad_d = 3'd1;
		else if (xhi && zlo) quad_d = 3'd2;
		else if (xhi && zhi) quad_d = 3'd3;
		else                 quad_d = qcq_pkg::QUAD_NONE;
	end

	// result register
	always_ff @(posedge clk) begin
		if (en_o) begin
			quadrant_q <= quad_d;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.quadrant = quadrant_q;

endmodule

@@ src/quadtree_child_quadrant_classify.sv @@
// ---------------------------------------------------------------------------
// quadtree_child_quadrant_classify
// Places a transformed box in one child quadrant of a quadtree node.
// ---------------------------------------------------------------------------
// path: product bank, two-entry queue, then four saturating adder stages and
//   the compare into the result register; one request per cycle unless stalled
//   by back-pressure from the result side
// load requests update the matrix on acceptance and give no result
// reset clears the matrix entries, node registers, queue and all valid flags
module quadtree_child_quadrant_classify (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	qcq_item_if.sink      items,
	qcq_result_if.source  results
);

	qcq_pkg::node_t node_q;
	qcq_pkg::work_t push_data, pop_data;
	logic push_valid, push_ready, pop_valid, pop_ready;

	// node configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				qcq_pkg::REG_CENTER_X: node_q.center_x <= cfg_data;
				qcq_pkg::REG_CENTER_Z: node_q.center_z <= cfg_data;
				qcq_pkg::REG_HALF_X:   node_q.half_x   <= cfg_data[30:0];
				qcq_pkg::REG_HALF_Z:   node_q.half_z   <= cfg_data[30:0];
				default:               node_q          <= node_q;
			endcase
		end
	end

	qcq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	qcq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	qcq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.node      (node_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.results   (results)
	);

	// a result never carries an unused quadrant code
	a_quad_range: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.quadrant <= qcq_pkg::QUAD_NONE))
		else $error("quadrant code out of range");

	// a matrix load leaves no product set behind
	a_load_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && items.func == qcq_pkg::FUNC_LOAD) |=> !push_valid)
		else $error("load request produced a queue entry");

	// a product set held back by a full queue stays offered
	a_push_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> push_valid)
		else $error("product set dropped while queue full");

endmodule

@@ test/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for quadtree_child_quadrant_classify: a short table of
// hand-picked requests, then random phases of matrix loads and boxes under
// varying node geometry, each box result checked against a pinned code or a
// local model of the Q16.16 transform and the quadrant containment test.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qcq_pkg::*;

	localparam int     SETTLE_CYCLES = 12;
	localparam int     DRAIN_CYCLES  = 16;
	localparam int     HOLD_CYCLES   = 300;
	localparam int     PHASES        = 12;
	localparam int     PHASE_REQS    = 142;
	localparam longint TIMEOUT_NS    = 2_000_000;
	localparam int     FX_ONE        = 65536;
	localparam longint Q_HI          = 64'sd2147483647;
	localparam longint Q_LO          = -64'sd2147483648;

	localparam q_t Q_ONE   = 32'sh0001_0000;
	localparam q_t Q_TWO   = 32'sh0002_0000;
	localparam q_t Q_FOUR  = 32'sh0004_0000;
	localparam q_t Q_EIGHT = 32'sh0008_0000;

	typedef struct packed {
		logic       func;
		q_t [7:0]   v;
	} req_t;

	typedef enum logic {ROW_REQ, ROW_NODE} row_kind_t;

	// one line of the directed table; node rows carry cx, cz, hx, hz in v[0..3]
	typedef struct {
		row_kind_t  kind;
		req_t       req;
		bit         pinned;
		logic [2:0] quad;
	} row_t;

	bit          clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	qcq_item_if   items ();
	qcq_result_if results ();

	quadtree_child_quadrant_classify i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.items     (items),
		.results   (results)
	);

	// model state: node geometry and latched matrix column entries
	q_t          node_cx = '0;
	q_t          node_cz = '0;
	logic [30:0] node_hx = '0;
	logic [30:0] node_hz = '0;
	q_t          mat_model [8] = '{default: '0};

	logic [2:0]  quad_expect [$];
	row_t        dir_rows [$];
	int          fail_count = 0;
	bit          sender_gaps = 1'b1;
	bit          sink_gaps = 1'b1;
	bit          hold_off_req = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// saturate to signed 32 bits
	function automatic q_t clamp_q(input longint x);
		if (x > Q_HI) begin
			return Q_MAX;
		end
		if (x < Q_LO) begin
			return Q_MIN;
		end
		return q_t'(x);
	endfunction

	// Q16.16 product, floor on the dropped bits
	function automatic q_t fx_mul(input q_t a, input q_t b);
		longint p;
		p = (longint'(a) * longint'(b)) >>> 16;
		return clamp_q(p);
	endfunction

	function automatic q_t fx_add(input q_t a, input q_t b);
		return clamp_q(longint'(a) + longint'(b));
	endfunction

	function automatic q_t fx_abs(input q_t a);
		return clamp_q(a < 0 ? -longint'(a) : longint'(a));
	endfunction

	// world footprint of one box and the first child that holds it
	function automatic logic [2:0] classify_box(input req_t r);
		q_t     wx, wz, ex, ez;
		longint h2x, h2z, ox, oz;
		wx = fx_add(fx_add(fx_add(fx_mul(r.v[3], mat_model[0]), fx_mul(r.v[4], mat_model[1])),
			fx_mul(r.v[5], mat_model[2])), mat_model[3]);
		wz = fx_add(fx_add(fx_add(fx_mul(r.v[3], mat_model[4]), fx_mul(r.v[4], mat_model[5])),
			fx_mul(r.v[5], mat_model[6])), mat_model[7]);
		ex = fx_add(fx_add(fx_abs(fx_mul(r.v[0], mat_model[0])),
			fx_abs(fx_mul(r.v[1], mat_model[1]))), fx_abs(fx_mul(r.v[2], mat_model[2])));
		ez = fx_add(fx_add(fx_abs(fx_mul(r.v[0], mat_model[4])),
			fx_abs(fx_mul(r.v[1], mat_model[5]))), fx_abs(fx_mul(r.v[2], mat_model[6])));
		h2x = longint'(node_hx) >> 1;
		h2z = longint'(node_hz) >> 1;
		for (int k = 0; k < 4; k++) begin
			ox = longint'(node_cx) + ((k & 2) != 0 ? h2x : -h2x);
			oz = longint'(node_cz) + ((k & 1) != 0 ? h2z : -h2z);
			if ((ox - h2x <= longint'(wx) - longint'(ex)) &&
			    (longint'(wx) + longint'(ex) <= ox + h2x) &&
			    (oz - h2z <= longint'(wz) - longint'(ez)) &&
			    (longint'(wz) + longint'(ez) <= oz + h2z)) begin
				return 3'(k);
			end
		end
		return QUAD_NONE;
	endfunction

	// signed value in [-span, span]
	function automatic q_t span_word(input longint span);
		longint s;
		s = span > 64'sd1073741823 ? 64'sd1073741823 : span;
		return q_t'(longint'($urandom_range(0, int'(2 * s))) - s);
	endfunction

	// full range word with the corners weighted up
	function automatic q_t noise_word();
		case ($urandom_range(0, 7))
			0: begin
				return Q_MAX;
			end
			1: begin
				return Q_MIN;
			end
			2: begin
				return '0;
			end
			3: begin
				return q_t'(-1);
			end
			default: begin
				return q_t'($urandom);
			end
		endcase
	endfunction

	// mostly plausible transforms and boxes sized to the node, some noise
	function automatic req_t random_request();
		req_t   r;
		longint span;
		bit     clean;
		span  = longint'(node_hx > node_hz ? node_hx : node_hz);
		span  = span < FX_ONE ? FX_ONE : span;
		clean = $urandom_range(0, 99) < 85;
		for (int k = 0; k < 8; k++) begin
			r.v[k] = noise_word();
		end
		if ($urandom_range(0, 4) == 0) begin
			r.func = FUNC_LOAD;
			if (clean) begin
				r.v[0] = span_word(2 * FX_ONE);
				r.v[1] = span_word(FX_ONE / 4);
				r.v[2] = span_word(FX_ONE / 2);
				r.v[3] = fx_add(node_cx, span_word(span));
				r.v[4] = span_word(FX_ONE / 2);
				r.v[5] = span_word(FX_ONE / 4);
				r.v[6] = span_word(2 * FX_ONE);
				r.v[7] = fx_add(node_cz, span_word(span));
			end
		end else begin
			r.func = FUNC_BOX;
			if (clean) begin
				r.v[0] = span_word(span / 8);
				r.v[1] = span_word(FX_ONE);
				r.v[2] = span_word(span / 8);
				r.v[3] = span_word(span);
				r.v[4] = span_word(FX_ONE);
				r.v[5] = span_word(span);
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] extreme_word();
		case ($urandom_range(0, 3))
			0: begin
				return Q_MAX;
			end
			1: begin
				return Q_MIN;
			end
			2: begin
				return '0;
			end
			default: begin
				return 32'hFFFF_FFFF;
			end
		endcase
	endfunction

	task automatic add_row(input row_kind_t kind, input logic func,
		input q_t a0, input q_t a1, input q_t a2, input q_t a3,
		input q_t a4, input q_t a5, input q_t a6, input q_t a7,
		input bit pinned, input logic [2:0] quad);
		row_t row;
		row.kind     = kind;
		row.req.func = func;
		row.req.v    = {a7, a6, a5, a4, a3, a2, a1, a0};
		row.pinned   = pinned;
		row.quad     = quad;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	// present one request, wait for it to be taken, then update the model
	task automatic offer(input req_t r, input bit pinned, input logic [2:0] pinned_quad);
		logic [2:0] want;
		if (sender_gaps && $urandom_range(0, 7) == 0) begin
			items.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		items.valid   <= 1'b1;
		items.func    <= r.func;
		items.value_0 <= r.v[0];
		items.value_1 <= r.v[1];
		items.value_2 <= r.v[2];
		items.value_3 <= r.v[3];
		items.value_4 <= r.v[4];
		items.value_5 <= r.v[5];
		items.value_6 <= r.v[6];
		items.value_7 <= r.v[7];
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		if (r.func == FUNC_LOAD) begin
			for (int k = 0; k < 8; k++) begin
				mat_model[k] = r.v[k];
			end
		end else begin
			want = pinned ? pinned_quad : classify_box(r);
			quad_expect.insert(quad_expect.size(), want);
		end
	endtask

	// block idle: all results in and the pipeline flushed
	task automatic settle();
		items.valid <= 1'b0;
		while (quad_expect.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_CENTER_X: begin
				node_cx = q_t'(data);
			end
			REG_CENTER_Z: begin
				node_cz = q_t'(data);
			end
			REG_HALF_X: begin
				node_hx = data[30:0];
			end
			default: begin
				node_hz = data[30:0];
			end
		endcase
	endtask

	task automatic write_node(input logic [31:0] cx, input logic [31:0] cz,
		input logic [31:0] hx, input logic [31:0] hz);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_HALF_X, hx);
		write_reg(REG_HALF_Z, hz);
		cfg_we <= 1'b0;
	endtask

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		results.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				results.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
				results.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			results.ready <= 1'b1;
		end
	end

	// compare each returned quadrant with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			if (quad_expect.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, expected none actual %0d",
					$realtime, results.quadrant);
			end else begin
				logic [2:0] want;
				want = quad_expect.pop_front();
				if (results.quadrant !== want) begin
					fail_count++;
					$display("%0t: quadrant mismatch, expected %0d actual %0d",
						$realtime, want, results.quadrant);
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("quadtree_child_quadrant_classify test failed");
		$finish;
	end

	initial begin
		logic [31:0] half_a, half_b;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_CENTER_X;
		cfg_data      <= '0;
		items.valid   <= 1'b0;
		items.func    <= FUNC_LOAD;
		items.value_0 <= '0;
		items.value_1 <= '0;
		items.value_2 <= '0;
		items.value_3 <= '0;
		items.value_4 <= '0;
		items.value_5 <= '0;
		items.value_6 <= '0;
		items.value_7 <= '0;

		// node at zero with zero size, zero matrix
		add_row(ROW_REQ, FUNC_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 1, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
			1, 3'd0);
		add_row(ROW_REQ, FUNC_LOAD, Q_ONE, 0, 0, 0, 0, 0, Q_ONE, 0, 0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 1, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, Q_ONE, 0, 0, 0, 0, 0, 0, 0, 1, QUAD_NONE);
		// 16x16 node at origin, identity matrix: one box per quadrant
		add_row(ROW_NODE, FUNC_BOX, 0, 0, Q_EIGHT, Q_EIGHT, 0, 0, 0, 0, 0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, Q_ONE, Q_ONE, Q_ONE, Q_TWO, 0, Q_TWO, 0, 0, 1, 3'd3);
		add_row(ROW_REQ, FUNC_BOX, Q_ONE, Q_ONE, Q_ONE, -Q_TWO, 0, Q_TWO, 0, 0, 0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, Q_ONE, Q_ONE, Q_ONE, Q_TWO, 0, -Q_TWO, 0, 0, 0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, Q_ONE, Q_ONE, Q_ONE, -Q_TWO, 0, -Q_TWO, 0, 0, 0, 3'd0);
		// straddles the split, then touches the closed child bounds
		add_row(ROW_REQ, FUNC_BOX, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, Q_FOUR, 0, Q_FOUR, Q_FOUR, 0, Q_FOUR, 0, 0, 0, 3'd0);
		// negative half extents
		add_row(ROW_REQ, FUNC_BOX, -Q_ONE, -Q_ONE, -Q_ONE, -Q_TWO, 0, -Q_TWO, 0, 0, 0, 3'd0);
		// saturating products and absolute value of the most negative word
		add_row(ROW_REQ, FUNC_LOAD, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0, 3'd0);
		// tiny entries: floor rounding of negative products
		add_row(ROW_REQ, FUNC_LOAD, 1, 0, 0, -1, 0, 0, 1, -1, 0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, -1, -1, -1, -1, -1, -1, -1, -1, 0, 3'd0);
		// extreme node, top bit of the half size ignored
		add_row(ROW_NODE, FUNC_BOX, Q_MAX, Q_MIN, 32'hFFFF_FFFF, Q_MAX, 0, 0, 0, 0, 0, 3'd0);
		add_row(ROW_REQ, FUNC_LOAD, Q_ONE, 0, 0, Q_MAX, 0, 0, Q_ONE, Q_MIN, 0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, Q_ONE, 0, Q_ONE, Q_MAX, 0, Q_MIN, 0, 0, 0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd0);
		add_row(ROW_NODE, FUNC_BOX, Q_MIN, Q_MAX, 0, 1, 0, 0, 0, 0, 0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3'd0);
		add_row(ROW_REQ, FUNC_BOX, Q_ONE, 0, Q_ONE, Q_MIN, Q_ONE, Q_MAX, 0, 0, 0, 3'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_NODE) begin
				settle();
				write_node(dir_rows[i].req.v[0], dir_rows[i].req.v[1],
					dir_rows[i].req.v[2], dir_rows[i].req.v[3]);
			end else begin
				offer(dir_rows[i].req, dir_rows[i].pinned, dir_rows[i].quad);
			end
		end

		// random phases, each under a fresh node
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			if (ph % 4 == 3) begin
				write_node(extreme_word(), extreme_word(), extreme_word(), extreme_word());
			end else begin
				half_a = {1'($urandom_range(0, 1)), 31'($urandom_range(FX_ONE, 64 * FX_ONE))};
				half_b = {1'($urandom_range(0, 1)), 31'($urandom_range(FX_ONE, 64 * FX_ONE))};
				write_node(span_word(256 * FX_ONE), span_word(256 * FX_ONE), half_a, half_b);
			end
			sender_gaps = (ph % 3 != 1) && (ph != 2) && (ph < PHASES - 1);
			sink_gaps   = (ph % 3 != 2) && (ph < PHASES - 1);
			// long stall on the result side while requests keep coming
			if (ph == 2) begin
				hold_off_req = 1'b1;
			end
			repeat (PHASE_REQS) offer(random_request(), 1'b0, 3'd0);
		end

		items.valid <= 1'b0;
		while (quad_expect.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("quadtree_child_quadrant_classify test passed");
		end else begin
			$display("quadtree_child_quadrant_classify test failed");
		end
		$finish;
	end

endmodule
